// ===== rtl/core/gcm_pkg.sv =====
`timescale 1ns / 1ps

package gcm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int NUM_GATES  = 5;
	localparam int GATE_IDX_W = 3;
	localparam int PULSE_W    = 5;

	localparam logic [GATE_IDX_W-1:0] LAST_GATE = GATE_IDX_W'(NUM_GATES - 1);
	localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd8192;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_EVAL,
		ST_OUT
	} gcm_state_t;

	typedef logic [NUM_GATES-1:0] gcm_gates_t;

endpackage

// ===== rtl/core/gcm_gate_step.sv =====
`timescale 1ns / 1ps

module gcm_gate_step #(
	parameter int COUNT_BITS = 24
) (
	input  logic [COUNT_BITS-1:0]          period,
	input  logic [gcm_pkg::GATE_IDX_W-1:0] gate_idx,
	input  logic [COUNT_BITS-1:0]          residue,
	input  logic [gcm_pkg::PULSE_W-1:0]    pulses,
	input  logic                           advance,
	output logic                           fire,
	output logic [COUNT_BITS-1:0]          residue_next,
	output logic [gcm_pkg::PULSE_W-1:0]    pulses_next
);
	import gcm_pkg::*;

	logic [COUNT_BITS-1:0] quot;
	logic [COUNT_BITS-1:0] quot_eff;
	logic [COUNT_BITS-1:0] res_inc;
	logic [PULSE_W-1:0]    factor;

	// residue tracks elapsed count modulo the gate spacing
	always_comb begin
		quot     = period >> gate_idx;
		quot_eff = (quot == '0) ? COUNT_BITS'(1) : quot;
		factor   = PULSE_W'(1) << gate_idx;
		fire     = (residue == '0) && (pulses < factor);
		pulses_next = fire ? pulses + PULSE_W'(1) : pulses;
		res_inc  = residue + COUNT_BITS'(1);
		if (!advance) begin
			// hold once the elapsed count has saturated
			residue_next = residue;
		end else if (res_inc == quot_eff) begin
			residue_next = '0;
		end else begin
			residue_next = res_inc;
		end
	end

endmodule

// ===== rtl/core/gate_clock_multiplier.sv =====
`timescale 1ns / 1ps
// Gate clock multiplier with period tracking.
// Input channel (in_valid / in_stall / clock_sample): one signed sample of an
// input clock per transaction. Output channel (out_valid / out_stall /
// gate_x1..gate_x16): one transaction of five one-sample gate pulses per input.
// gate_threshold is written with threshold_we; the user must write it only
// while the block is idle, which the block itself does not enforce. Each
// sample runs through the edge state, then through a shared compare/update unit
// in the eval state (one gate per cycle), then through the output state, which
// loads the output register. A new sample is taken only after the previous one
// has left the output state. The output register holds a finished result
// while the next sample is accepted and worked; if the result is still
// stalled when the next one is done, the block waits in its output state
// with in_stall high.
// Reset clears the threshold to 8192, the period to RESET_PERIOD, the elapsed
// count, edge flag and pulse counters, and empties the output register.
module gate_clock_multiplier #(
	parameter int COUNT_BITS   = 24,
	parameter int RESET_PERIOD = 48000
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               threshold_we,
	input  logic signed [gcm_pkg::SAMPLE_W-1:0] gate_threshold,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [gcm_pkg::SAMPLE_W-1:0] clock_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               gate_x1,
	output logic                               gate_x2,
	output logic                               gate_x4,
	output logic                               gate_x8,
	output logic                               gate_x16
);
	import gcm_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] PERIOD_INIT = COUNT_BITS'(RESET_PERIOD);

	gcm_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] thr_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       input_high_q;
	logic [COUNT_BITS-1:0]      elapsed_q;
	logic [COUNT_BITS-1:0]      period_q;
	logic [PULSE_W-1:0]         pulses_q  [NUM_GATES];
	logic [COUNT_BITS-1:0]      residue_q [NUM_GATES];
	logic [GATE_IDX_W-1:0]      k_q;
	gcm_gates_t                 fire_q;
	gcm_gates_t                 gates_q;
	logic                       out_valid_q;

	logic                  in_accept;
	logic                  out_take;
	logic                  out_load;
	logic                  edge_seen;
	logic                  advance;
	logic                  step_fire;
	logic [COUNT_BITS-1:0] step_residue;
	logic [PULSE_W-1:0]    step_pulses;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_take  = out_valid_q && !out_stall;
	assign edge_seen = !input_high_q && (sample_q > thr_q);
	assign advance   = (elapsed_q != COUNT_MAX);

	assign gate_x1  = gates_q[0];
	assign gate_x2  = gates_q[1];
	assign gate_x4  = gates_q[2];
	assign gate_x8  = gates_q[3];
	assign gate_x16 = gates_q[4];

	gcm_gate_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.period       (period_q),
		.gate_idx     (k_q),
		.residue      (residue_q[k_q]),
		.pulses       (pulses_q[k_q]),
		.advance      (advance),
		.fire         (step_fire),
		.residue_next (step_residue),
		.pulses_next  (step_pulses)
	);

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) state_d = ST_EDGE;
			end
			ST_EDGE: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (k_q == LAST_GATE) state_d = ST_OUT;
			end
			ST_OUT: begin
				// wait for room in the output register
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (threshold_we) begin
			thr_q <= gate_threshold;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) sample_q <= clock_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_high_q <= 1'b0;
			elapsed_q    <= '0;
			period_q     <= PERIOD_INIT;
			k_q          <= '0;
			for (int i = 0; i < NUM_GATES; i++) begin
				pulses_q[i]  <= '0;
				residue_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_EDGE: begin
					if (edge_seen) begin
						period_q     <= elapsed_q;
						elapsed_q    <= '0;
						input_high_q <= 1'b1;
						for (int i = 0; i < NUM_GATES; i++) begin
							pulses_q[i]  <= '0;
							residue_q[i] <= '0;
						end
					end else if (input_high_q && (sample_q <= thr_q)) begin
						input_high_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					pulses_q[k_q]  <= step_pulses;
					residue_q[k_q] <= step_residue;
					if (k_q == LAST_GATE) begin
						k_q <= '0;
						if (advance) elapsed_q <= elapsed_q + COUNT_BITS'(1);
					end else begin
						k_q <= k_q + GATE_IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) fire_q[k_q] <= step_fire;
		if (out_load) gates_q <= fire_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_to_edge: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_EDGE)
		else $error("accepted sample did not start edge check");

	a_eval_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && k_q == LAST_GATE) |=> state_q == ST_OUT)
		else $error("gate sequence did not end at the last gate");

	a_high_from_edge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(input_high_q) |-> $past(state_q == ST_EDGE))
		else $error("edge flag set outside edge check");

	a_cap_x1: assert property (@(posedge clk) disable iff (!arst_n)
		pulses_q[0] <= PULSE_W'(1))
		else $error("gate x1 exceeded its pulse cap");

	a_cap_x16: assert property (@(posedge clk) disable iff (!arst_n)
		pulses_q[4] <= PULSE_W'(16))
		else $error("gate x16 exceeded its pulse cap");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gcm_pkg::*;

	localparam int COUNT_BITS = 24;
	localparam int RESET_PERIOD = 48000;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic threshold_we;
	logic signed [SAMPLE_W-1:0] gate_threshold;
	logic in_valid;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] clock_sample;
	logic out_valid;
	logic out_stall;
	logic gate_x1, gate_x2, gate_x4, gate_x8, gate_x16;

	// Predictor state
	logic signed [SAMPLE_W-1:0] thr_model;
	bit high_model;
	logic [COUNT_BITS-1:0] elapsed_model;
	logic [COUNT_BITS-1:0] period_model;
	logic [PULSE_W-1:0] pulses_model [NUM_GATES];

	gcm_gates_t pending_gates [$];
	int error_count;
	int idle_count;
	bit gaps_enabled;
	int hold_request;

	gate_clock_multiplier #(
		.COUNT_BITS(COUNT_BITS),
		.RESET_PERIOD(RESET_PERIOD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.threshold_we(threshold_we),
		.gate_threshold(gate_threshold),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.clock_sample(clock_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gate_x1(gate_x1),
		.gate_x2(gate_x2),
		.gate_x4(gate_x4),
		.gate_x8(gate_x8),
		.gate_x16(gate_x16)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic gcm_gates_t step_gates(input logic signed [SAMPLE_W-1:0] s);
		gcm_gates_t g;
		logic [COUNT_BITS-1:0] q;
		g = '0;
		if (!high_model && s > thr_model) begin
			period_model = elapsed_model;
			elapsed_model = '0;
			high_model = 1'b1;
			for (int k = 0; k < NUM_GATES; k++) pulses_model[k] = '0;
		end else if (high_model && s <= thr_model) begin
			high_model = 1'b0;
		end
		for (int k = 0; k < NUM_GATES; k++) begin
			// factor of gate k is 2**k
			q = period_model >> k;
			if (q == '0) q = COUNT_BITS'(1);
			if ((elapsed_model % q) == '0 && pulses_model[k] < (1 << k)) begin
				pulses_model[k] = pulses_model[k] + 1'b1;
				g[k] = 1'b1;
			end
		end
		if (elapsed_model != COUNT_MAX) elapsed_model = elapsed_model + 1'b1;
		return g;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] high_level();
		int lo;
		lo = thr_model + 1;
		if (lo > 32767) return 16'sh7fff;
		return SAMPLE_W'(lo + $urandom_range(0, 32767 - lo));
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] low_level();
		return SAMPLE_W'(-32768 + $urandom_range(0, thr_model + 32768));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Offer one sample and hold it until the block takes it; valid stays up.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		@(negedge clk);
		in_valid <= 1'b1;
		clock_sample <= s;
		do @(posedge clk); while (in_stall);
		pending_gates.push_back(step_gates(s));
	endtask

	task automatic input_gap();
		int n;
		if (!gaps_enabled) return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
		if (n == 0) return;
		@(negedge clk);
		in_valid <= 1'b0;
		clock_sample <= SAMPLE_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_gates.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic signed [SAMPLE_W-1:0] v);
		drop_input();
		wait_drained();
		@(negedge clk);
		threshold_we <= 1'b1;
		gate_threshold <= v;
		@(negedge clk);
		threshold_we <= 1'b0;
		thr_model = v;
	endtask

	// Edge on the first sample, staying high, clearing at exactly the threshold,
	// short periods that drive the quotients to zero.
	task automatic test_first_edge();
		logic signed [SAMPLE_W-1:0] seq [$];
		seq = '{16'sh7fff, 16'sh7fff, 16'sd8192, 16'sd8192, 16'sd8193, -16'sd32768,
			16'sd8193, 16'sd0, 16'sd0, 16'sd20000, 16'sd8192, 16'sd8193};
		gaps_enabled = 1'b0;
		foreach (seq[i]) send_sample(seq[i]);
	endtask

	task automatic test_threshold_extremes();
		gaps_enabled = 1'b1;
		write_threshold(16'sh7fff);
		send_sample(16'sh7fff);
		input_gap();
		send_sample(-16'sd32768);
		input_gap();
		send_sample(16'sh7fff);
		write_threshold(-16'sd32768);
		send_sample(-16'sd32767);
		input_gap();
		send_sample(-16'sd32768);
		input_gap();
		send_sample(16'sh5555);
		input_gap();
		send_sample(-16'sd32768);
		input_gap();
		send_sample(16'shaaaa);
		input_gap();
		send_sample(-16'sd32768);
	endtask

	// Hold the output long enough for the block to fill and stall its input.
	task automatic test_output_backpressure();
		write_threshold(THRESHOLD_RESET);
		gaps_enabled = 1'b0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 20; i++) send_sample((i % 3 == 0) ? high_level() : low_level());
	endtask

	task automatic run_waves(input int n_items);
		int sent, per, high_len;
		logic signed [SAMPLE_W-1:0] s;
		sent = 0;
		while (sent < n_items) begin
			per = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
			high_len = $urandom_range(1, per);
			for (int i = 0; i < per && sent < n_items; i++) begin
				if ($urandom_range(0, 24) == 0) s = SAMPLE_W'($urandom);
				else if (i < high_len) s = high_level();
				else s = low_level();
				send_sample(s);
				input_gap();
				sent++;
			end
		end
	endtask

	task automatic test_random_waves();
		logic signed [SAMPLE_W-1:0] thr_list [$];
		thr_list = '{THRESHOLD_RESET, 16'sd0, -16'sd1, 16'sd32766, -16'sd32767,
			16'($urandom), 16'($urandom)};
		foreach (thr_list[i]) begin
			write_threshold(thr_list[i]);
			gaps_enabled = (i % 3 != 2);
			run_waves(85);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		threshold_we = 1'b0;
		gate_threshold = THRESHOLD_RESET;
		in_valid = 1'b0;
		clock_sample = '0;
		error_count = 0;
		gaps_enabled = 1'b0;
		hold_request = 0;
		thr_model = THRESHOLD_RESET;
		high_model = 1'b0;
		elapsed_model = '0;
		period_model = COUNT_BITS'(RESET_PERIOD);
		for (int k = 0; k < NUM_GATES; k++) pulses_model[k] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_first_edge();
		test_threshold_extremes();
		test_output_backpressure();
		test_random_waves();

		drop_input();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("gate_clock_multiplier verification clean");
		end else begin
			$display("gate_clock_multiplier verification failed");
		end
		$finish;
	end

	// Output stall: random runs, a long hold on request, no new random runs while gaps are off.
	initial begin
		int hold_left, stall_left, free_left;
		hold_left = 0;
		stall_left = 0;
		free_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (free_left > 0 || !gaps_enabled) begin
				out_stall <= 1'b0;
				if (free_left > 0) free_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 3);
				free_left = $urandom_range(0, 6);
			end
		end
	end

	always @(posedge clk) begin
		gcm_gates_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {gate_x16, gate_x8, gate_x4, gate_x2, gate_x1};
			if (pending_gates.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, gates %b", got));
			end else begin
				want = pending_gates.pop_front();
				for (int k = 0; k < NUM_GATES; k++)
					if (got[k] !== want[k])
						report_mismatch($sformatf("gate_x%0d got %b want %b",
							1 << k, got[k], want[k]));
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= STALL_LIMIT) begin
			$display("gate_clock_multiplier verification failed");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

endmodule
